@@ hdl/itdt_pkg.sv @@
package itdt_pkg;

    // ascii codes of the emitted characters
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    // commands from the sequencer to the conversion unit
    typedef struct packed {
        logic start;
        logic shift;
    } dab_cmd_t;

    // decimal digits in the largest magnitude 2^(bits-1)
    function automatic int dec_digits(int bits);
        longint unsigned m;
        int n;
        m = 64'd1 << (bits - 1);
        n = 0;
        do
        begin
            n++;
            m = m / 10;
        end
        while (m != 0);
        return n;
    endfunction

endpackage

@@ hdl/itdt_value_if.sv @@
interface itdt_value_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/itdt_char_if.sv @@
interface itdt_char_if;
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ hdl/itdt_dabble.sv @@
module itdt_dabble #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  itdt_pkg::dab_cmd_t    cmd,
    input  logic [VALUE_BITS-1:0] mag,
    output logic                  done,
    output logic [3:0]            top_digit
);

    localparam int NDIG    = itdt_pkg::dec_digits(VALUE_BITS);
    localparam int BCDW    = 4 * NDIG;
    localparam int CNTW    = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [BCDW-1:0]       bcd_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  busy_reg;
    logic [BCDW-1:0]       corrected;

    // add-3 correction on every digit that is five or more
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                corrected[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                corrected[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // control: one magnitude bit per cycle while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(VALUE_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: bit shift into bcd, then digit shift out from the top
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {corrected[BCDW-2:0], mag_reg[VALUE_BITS-1]};
        end
        else if (cmd.shift)
        begin
            bcd_reg <= {bcd_reg[BCDW-5:0], 4'd0};
        end
    end

    assign done      = !busy_reg;
    assign top_digit = bcd_reg[BCDW-1 -: 4];

endmodule

@@ hdl/int_to_decimal_text.sv @@
// int_to_decimal_text: signed integer to decimal ascii text
//
// num_in carries one two's complement value per beat. text_out carries
// the characters of its decimal text, most significant first, one per
// beat: a '-' for a negative value, then the digits of the magnitude
// without leading zeros. last marks the final character of each number.
//
// The magnitude goes through a bit-serial double dabble unit, one bit per
// cycle. The digits are then shifted out of the bcd register one per
// cycle while the receiver keeps up; leading zero digits are dropped at
// one per cycle. A '-' is made valid once the conversion is done and the
// output register is free. NDIG is 10 at 32 bits. One number is in work
// at a time; num_in is ready only between numbers.
//
// A character sits in an output register; while the receiver stalls it
// holds and the sequencer waits. The next number can be accepted while the
// last character of the previous one is still waiting. Reset clears the
// sequencer and the output valid; no state carries across numbers.
module int_to_decimal_text #(
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    itdt_value_if.sink        num_in,
    itdt_char_if.source       text_out
);

    localparam int NDIG = itdt_pkg::dec_digits(VALUE_BITS);
    localparam int REMW = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic                  neg_reg;
    logic [REMW-1:0]       rem_reg;
    logic                  out_valid_reg;
    logic [5:0]            char_reg;
    logic                  last_reg;

    itdt_pkg::dab_cmd_t    cmd;
    logic [VALUE_BITS-1:0] mag;
    logic                  dab_done;
    logic [3:0]            top_digit;
    logic                  in_beat;
    logic                  out_free;

    assign in_beat  = num_in.valid && num_in.ready;
    assign out_free = !out_valid_reg || text_out.ready;

    // magnitude at full width, exact for the most negative value
    assign mag = num_in.value[VALUE_BITS-1] ? (~num_in.value + 1'b1) : num_in.value;

    // commands to the conversion unit
    always_comb
    begin
        cmd.start = in_beat;
        cmd.shift = 1'b0;
        case (state_reg)
            S_SKIP:
            begin
                cmd.shift = (top_digit == 4'd0) && (rem_reg > REMW'(1));
            end
            S_EMIT:
            begin
                cmd.shift = out_free;
            end
            default:
            begin
                cmd.shift = 1'b0;
            end
        endcase
    end

    itdt_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mag       (mag),
        .done      (dab_done),
        .top_digit (top_digit)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && text_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        neg_reg   <= num_in.value[VALUE_BITS-1];
                        rem_reg   <= REMW'(NDIG);
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    if (dab_done && (!neg_reg || out_free))
                    begin
                        if (neg_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            char_reg      <= itdt_pkg::CHAR_MINUS;
                            last_reg      <= 1'b0;
                        end
                        state_reg <= S_SKIP;
                    end
                end
                S_SKIP:
                begin
                    if (cmd.shift)
                    begin
                        rem_reg <= rem_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= itdt_pkg::CHAR_ZERO + {2'b00, top_digit};
                        last_reg      <= (rem_reg == REMW'(1));
                        rem_reg       <= rem_reg - 1'b1;
                        if (rem_reg == REMW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign num_in.ready       = (state_reg == S_IDLE);
    assign text_out.valid     = out_valid_reg;
    assign text_out.char_code = char_reg;
    assign text_out.last      = last_reg;

    // only a minus sign or a decimal digit leaves the block
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == itdt_pkg::CHAR_MINUS) ||
            ((char_reg >= itdt_pkg::CHAR_ZERO) &&
             (char_reg <= itdt_pkg::CHAR_ZERO + {2'b00, itdt_pkg::DIGIT_MAX})))
        else $error("character code out of range");

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == itdt_pkg::CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as last");

    // an accepted number starts a conversion at once
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_CONV) && !dab_done)
        else $error("conversion did not start");

    // digit count stays within the bcd register
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= REMW'(NDIG))
        else $error("digit count overflow");

    // the last character always closes the number
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && rem_reg == REMW'(1)) |=>
            (state_reg == S_IDLE) && last_reg)
        else $error("last character did not end the number");

endmodule
